### design/plac_pkg.sv
// ----------------------------------------------------------------------------
// plac_pkg
// Shared types and constants of the path loop and containment block.
// ----------------------------------------------------------------------------
package plac_pkg;

  localparam int PT_DEPTH_DEF    = 512;
  localparam int COORD_BITS_DEF  = 16;
  localparam int MIN_LOOP_POINTS = 4;

  localparam logic [9:0] PATH_LIMIT_RST = 10'd512;

  // request codes
  localparam logic [1:0] REQ_APPEND = 2'd0;
  localparam logic [1:0] REQ_LOOP   = 2'd1;
  localparam logic [1:0] REQ_INSIDE = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // register index of path_limit
  localparam logic REG_PATH_LIMIT = 1'b0;

  // controller to datapath commands
  typedef struct packed {
    logic take_in;
    logic clr_res;
    logic append;
    logic rd_en;
    logic cap_a0;
    logic cap_a1;
    logic cap_q0;
    logic cap_q1;
    logic shift_q;
    logic lp_mul;
    logic lp_cmp;
    logic cap_pj;
    logic cap_pi;
    logic pp_mul;
    logic pp_cmp;
    logic out_load;
  } plac_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;
    logic lp_hit;
  } plac_st_t;

endpackage

### design/plac_ram.sv
// ----------------------------------------------------------------------------
// plac_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module plac_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/plac_ctrl.sv
// ----------------------------------------------------------------------------
// plac_ctrl
// Sequencer for append, segment pair walk and ray crossing walk.
// ----------------------------------------------------------------------------
module plac_ctrl import plac_pkg::*; #(
  parameter int PT_DEPTH = PT_DEPTH_DEF,
  parameter int AW       = $clog2(PT_DEPTH),
  parameter int CW       = $clog2(PT_DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [1:0]    in_req_i,
  output logic          in_ready_o,
  input  logic [CW-1:0] cnt_i,
  input  plac_st_t      st_i,
  output plac_cmd_t     cmd_o,
  output logic [AW-1:0] k_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_APP   = 4'd1;
  localparam logic [3:0] S_FIN   = 4'd2;
  localparam logic [3:0] S_LA0   = 4'd3;
  localparam logic [3:0] S_LA1   = 4'd4;
  localparam logic [3:0] S_LB0   = 4'd5;
  localparam logic [3:0] S_LB1   = 4'd6;
  localparam logic [3:0] S_LC    = 4'd7;
  localparam logic [3:0] S_LD    = 4'd8;
  localparam logic [3:0] S_LE    = 4'd9;
  localparam logic [3:0] S_PINIT = 4'd10;
  localparam logic [3:0] S_PJ    = 4'd11;
  localparam logic [3:0] S_PI    = 4'd12;
  localparam logic [3:0] S_PM    = 4'd13;
  localparam logic [3:0] S_PE    = 4'd14;

  localparam int NW = CW + 2;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d;
  logic [NW-1:0] nn, ii, jj, kk;

  assign nn = NW'(cnt_i);
  assign ii = NW'(i_q);
  assign jj = NW'(j_q);

  always_comb begin
    state_d    = state_q;
    i_d        = i_q;
    j_d        = j_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    kk         = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take_in = 1'b1;
          cmd_o.clr_res = 1'b1;
          case (in_req_i)
            REQ_APPEND: state_d = S_APP;
            REQ_LOOP: begin
              i_d = '0;
              if (nn < NW'(MIN_LOOP_POINTS)) state_d = S_FIN;
              else state_d = S_LA0;
            end
            REQ_INSIDE: begin
              if (nn == '0) state_d = S_FIN;
              else state_d = S_PINIT;
            end
            default: state_d = S_FIN;
          endcase
        end
      end
      S_APP: begin
        cmd_o.append = 1'b1;
        state_d      = S_FIN;
      end
      S_FIN: begin
        if (st_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_LA0: begin
        cmd_o.rd_en = 1'b1;
        kk          = ii;
        state_d     = S_LA1;
      end
      S_LA1: begin
        cmd_o.cap_a0 = 1'b1;
        cmd_o.rd_en  = 1'b1;
        kk           = ii + NW'(1);
        state_d      = S_LB0;
      end
      S_LB0: begin
        cmd_o.cap_a1 = 1'b1;
        cmd_o.rd_en  = 1'b1;
        kk           = ii + NW'(2);
        j_d          = CW'(ii + NW'(2));
        state_d      = S_LB1;
      end
      S_LB1: begin
        cmd_o.cap_q0 = 1'b1;
        cmd_o.rd_en  = 1'b1;
        kk           = jj + NW'(1);
        state_d      = S_LC;
      end
      S_LC: begin
        cmd_o.cap_q1 = 1'b1;
        state_d      = S_LD;
      end
      S_LD: begin
        cmd_o.lp_mul = 1'b1;
        state_d      = S_LE;
      end
      S_LE: begin
        cmd_o.lp_cmp = 1'b1;
        if (st_i.lp_hit) begin
          state_d = S_FIN;
        end else if (jj + NW'(2) < nn) begin
          // slide the second segment one point on
          j_d           = CW'(jj + NW'(1));
          cmd_o.shift_q = 1'b1;
          cmd_o.rd_en   = 1'b1;
          kk            = jj + NW'(2);
          state_d       = S_LC;
        end else if (ii + NW'(4) < nn) begin
          i_d     = CW'(ii + NW'(1));
          state_d = S_LA0;
        end else begin
          state_d = S_FIN;
        end
      end
      S_PINIT: begin
        cmd_o.rd_en = 1'b1;
        kk          = nn - NW'(1);
        state_d     = S_PJ;
      end
      S_PJ: begin
        cmd_o.cap_pj = 1'b1;
        cmd_o.rd_en  = 1'b1;
        i_d          = '0;
        kk           = '0;
        state_d      = S_PI;
      end
      S_PI: begin
        cmd_o.cap_pi = 1'b1;
        state_d      = S_PM;
      end
      S_PM: begin
        cmd_o.pp_mul = 1'b1;
        state_d      = S_PE;
      end
      S_PE: begin
        cmd_o.pp_cmp = 1'b1;
        if (ii + NW'(1) < nn) begin
          i_d         = CW'(ii + NW'(1));
          cmd_o.rd_en = 1'b1;
          kk          = ii + NW'(1);
          state_d     = S_PI;
        end else begin
          state_d = S_FIN;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign k_o = kk[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
    end
  end

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> st_i.out_free)
    else $error("result loaded while output register busy");

  a_pair_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LC || state_q == S_LD || state_q == S_LE) |-> (jj >= ii + NW'(2)))
    else $error("segment pair not separated");

  a_pair_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LE) |-> (jj + NW'(1) < nn))
    else $error("segment end beyond stored points");

endmodule

### design/plac_dp.sv
// ----------------------------------------------------------------------------
// plac_dp
// Point store, window pointers, geometry arithmetic and result register.
// ----------------------------------------------------------------------------
module plac_dp import plac_pkg::*; #(
  parameter int PT_DEPTH   = PT_DEPTH_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int AW         = $clog2(PT_DEPTH),
  parameter int CW         = $clog2(PT_DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  plac_cmd_t     cmd_i,
  input  logic [AW-1:0] k_i,
  input  logic [1:0]    in_req_i,
  input  logic [15:0]   in_x_i,
  input  logic [15:0]   in_y_i,
  input  logic [9:0]    limit_i,
  input  logic          m_ready_i,
  output logic          m_valid_o,
  output logic [15:0]   m_data_o,
  output logic [CW-1:0] cnt_o,
  output plac_st_t      st_o
);

  localparam int CB = COORD_BITS;
  localparam int DW = CB + 1;
  localparam int PW = 2 * DW;
  localparam int LW = (CW > 10) ? CW : 10;

  logic [AW-1:0] oldest_q, oldest_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [1:0]    req_q;
  logic signed [CB-1:0] px_q, py_q;
  logic signed [CB-1:0] a0x_q, a0y_q, a1x_q, a1y_q, q0x_q, q0y_q, q1x_q, q1y_q;
  logic signed [CB-1:0] pjx_q, pjy_q, pix_q, piy_q;
  logic signed [PW-1:0] axby_q, aybx_q, dxay_q, dyax_q, dxby_q, dybx_q;
  logic signed [PW-1:0] lhs_q, rhs_q;
  logic                 strad_q, eypos_q;
  logic                 res_q;
  logic                 out_valid_q;
  logic [15:0]          out_data_q;

  // input coordinates from the low bits of the fields
  logic [31:0]          raw_x, raw_y;
  logic signed [CB-1:0] cx, cy;
  assign raw_x = {16'b0, in_x_i};
  assign raw_y = {16'b0, in_y_i};
  assign cx    = raw_x[CB-1:0];
  assign cy    = raw_y[CB-1:0];

  // read address: oldest plus offset, wrapped once
  logic [AW:0]   rsum;
  logic [AW-1:0] raddr;
  logic [2*CB-1:0] rdata;
  logic signed [CB-1:0] rd_x, rd_y;
  assign rsum  = {1'b0, oldest_q} + (AW+1)'(k_i);
  assign raddr = (rsum >= (AW+1)'(PT_DEPTH)) ?
                 AW'(rsum - (AW+1)'(PT_DEPTH)) : AW'(rsum);
  assign rd_x  = rdata[CB-1:0];
  assign rd_y  = rdata[2*CB-1:CB];

  // append slot and window update
  logic [AW:0]   wsum;
  logic [AW-1:0] waddr;
  logic [LW-1:0] lim_w;
  logic [CW-1:0] lim;
  logic [CW:0]   cnt_inc, drop;
  logic [AW+1:0] osum;
  assign wsum  = {1'b0, oldest_q} + (AW+1)'(cnt_q);
  assign waddr = (wsum >= (AW+1)'(PT_DEPTH)) ?
                 AW'(wsum - (AW+1)'(PT_DEPTH)) : AW'(wsum);

  always_comb begin
    lim_w = LW'(limit_i);
    if (lim_w < LW'(MIN_LOOP_POINTS)) lim_w = LW'(MIN_LOOP_POINTS);
    if (lim_w > LW'(PT_DEPTH)) lim_w = LW'(PT_DEPTH);
    lim      = CW'(lim_w);
    cnt_inc  = (CW+1)'(cnt_q) + (CW+1)'(1);
    drop     = cnt_inc - (CW+1)'(lim);
    osum     = (AW+2)'(oldest_q) + (AW+2)'(drop);
    oldest_d = oldest_q;
    cnt_d    = cnt_q;
    if (cmd_i.append) begin
      if (cnt_inc > (CW+1)'(lim)) begin
        // window full: drop the oldest points
        oldest_d = (osum >= (AW+2)'(PT_DEPTH)) ?
                   AW'(osum - (AW+2)'(PT_DEPTH)) : AW'(osum);
        cnt_d    = lim;
      end else begin
        cnt_d = CW'(cnt_inc);
      end
    end
  end

  plac_ram #(
    .WIDTH (2 * CB),
    .DEPTH (PT_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.append),
    .waddr_i (waddr),
    .wdata_i ({py_q, px_q}),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // segment crossing terms
  logic signed [DW-1:0] ax, ay, bx, by, dx, dy;
  assign ax = DW'(a1x_q) - DW'(a0x_q);
  assign ay = DW'(a1y_q) - DW'(a0y_q);
  assign bx = DW'(q1x_q) - DW'(q0x_q);
  assign by = DW'(q1y_q) - DW'(q0y_q);
  assign dx = DW'(q0x_q) - DW'(a0x_q);
  assign dy = DW'(q0y_q) - DW'(a0y_q);

  logic signed [PW:0] den, nu, nt;
  assign den = (PW+1)'(axby_q) - (PW+1)'(aybx_q);
  assign nu  = (PW+1)'(dxay_q) - (PW+1)'(dyax_q);
  assign nt  = (PW+1)'(dxby_q) - (PW+1)'(dybx_q);

  logic lp_hit;

  always_comb begin
    if (den > 0) begin
      lp_hit = (nu > 0) && (nu < den) && (nt > 0) && (nt < den);
    end else if (den < 0) begin
      lp_hit = (nu < 0) && (nu > den) && (nt < 0) && (nt > den);
    end else begin
      lp_hit = 1'b0;
    end
  end

  // ray crossing terms
  logic signed [DW-1:0] ey, ty, ex, tx;
  logic                 strad, pp_hit;
  assign ey     = DW'(pjy_q) - DW'(piy_q);
  assign ty     = DW'(py_q) - DW'(piy_q);
  assign ex     = DW'(pjx_q) - DW'(pix_q);
  assign tx     = DW'(px_q) - DW'(pix_q);
  assign strad  = ((piy_q < py_q) && (pjy_q >= py_q)) ||
                  ((pjy_q < py_q) && (piy_q >= py_q));
  assign pp_hit = strad_q && (eypos_q ? (lhs_q < rhs_q) : (lhs_q > rhs_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) begin
      req_q <= in_req_i;
      px_q  <= cx;
      py_q  <= cy;
    end
    if (cmd_i.cap_a0) begin
      a0x_q <= rd_x;
      a0y_q <= rd_y;
    end
    if (cmd_i.cap_a1) begin
      a1x_q <= rd_x;
      a1y_q <= rd_y;
    end
    if (cmd_i.cap_q0) begin
      q0x_q <= rd_x;
      q0y_q <= rd_y;
    end else if (cmd_i.shift_q) begin
      q0x_q <= q1x_q;
      q0y_q <= q1y_q;
    end
    if (cmd_i.cap_q1) begin
      q1x_q <= rd_x;
      q1y_q <= rd_y;
    end
    if (cmd_i.lp_mul) begin
      axby_q <= ax * by;
      aybx_q <= ay * bx;
      dxay_q <= dx * ay;
      dyax_q <= dy * ax;
      dxby_q <= dx * by;
      dybx_q <= dy * bx;
    end
    if (cmd_i.cap_pj) begin
      pjx_q <= rd_x;
      pjy_q <= rd_y;
    end else if (cmd_i.pp_cmp) begin
      pjx_q <= pix_q;
      pjy_q <= piy_q;
    end
    if (cmd_i.cap_pi) begin
      pix_q <= rd_x;
      piy_q <= rd_y;
    end
    if (cmd_i.pp_mul) begin
      lhs_q   <= ty * ex;
      rhs_q   <= tx * ey;
      strad_q <= strad;
      eypos_q <= (ey > 0);
    end
  end

  assign st_o = '{out_free: !out_valid_q || m_ready_i, lp_hit: lp_hit};

  logic [31:0] cnt_ext;
  assign cnt_ext = 32'(cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q    <= '0;
      cnt_q       <= '0;
      res_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      oldest_q <= oldest_d;
      cnt_q    <= cnt_d;
      if (cmd_i.clr_res) begin
        res_q <= 1'b0;
      end else if (cmd_i.lp_cmp && lp_hit) begin
        res_q <= 1'b1;
      end else if (cmd_i.pp_cmp && pp_hit) begin
        res_q <= !res_q;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
        out_data_q  <= {4'b0, cnt_ext[9:0],
                        (req_q == REQ_INSIDE) && res_q,
                        (req_q == REQ_LOOP) && res_q};
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_data_q;
  assign cnt_o     = cnt_q;

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(PT_DEPTH))
    else $error("point count above store depth");

  a_oldest_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (AW+1)'(oldest_q) < (AW+1)'(PT_DEPTH))
    else $error("oldest slot outside store");

  a_append_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.append |=> (cnt_q != '0))
    else $error("count zero after append");

endmodule

### design/path_loop_and_containment.sv
// ----------------------------------------------------------------------------
// path_loop_and_containment
// Sliding window path store with self crossing and even-odd containment.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tuser req_type, tdata pos_x, pos_y
//  m_axis    out  m_axis_tvalid/tready      tdata loop_found, inside_res, held
//  apb       in   psel/penable/pready       path_limit at byte address 0
//
//  The point store has a single read port. A loop query ends at the first hit.
//  One request at a time; a finished result waits in the output register
//  and a stalled m_axis holds the sequencer in its final state.
//  Reset clears the window pointers, not the store; the store needs no clearing pass.
// ----------------------------------------------------------------------------
module path_loop_and_containment import plac_pkg::*; #(
  parameter int PT_DEPTH   = PT_DEPTH_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] pos_x, [31:16] pos_y
  input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [0] loop_found, [1] inside_res,
                                      // [11:2] points_held, [15:12] zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(PT_DEPTH);
  localparam int CW = $clog2(PT_DEPTH + 1);

  logic [9:0]    limit_q;
  plac_cmd_t     cmd;
  plac_st_t      st;
  logic [AW-1:0] k;
  logic [CW-1:0] cnt;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_PATH_LIMIT) ? {22'b0, limit_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= PATH_LIMIT_RST;
    end else if (psel && penable && pwrite && paddr[2] == REG_PATH_LIMIT) begin
      limit_q <= pwdata[9:0];
    end
  end

  plac_ctrl #(
    .PT_DEPTH (PT_DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_req_i   (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .cnt_i      (cnt),
    .st_i       (st),
    .cmd_o      (cmd),
    .k_o        (k)
  );

  plac_dp #(
    .PT_DEPTH   (PT_DEPTH),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .k_i       (k),
    .in_req_i  (s_axis_tuser),
    .in_x_i    (s_axis_tdata[15:0]),
    .in_y_i    (s_axis_tdata[31:16]),
    .limit_i   (limit_q),
    .m_ready_i (m_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_data_o  (m_axis_tdata),
    .cnt_o     (cnt),
    .st_o      (st)
  );

endmodule
